### hdl/lobt_pkg.sv
// Shared types and constants for the limit order book table core.
// No dependencies; imported by every module of the block but lobt_ram.
package lobt_pkg;

    localparam int MAX_ORDERS_DEF = 256;
    localparam int MAX_LEVELS_DEF = 64;
    localparam int MAX_LIST_DEF   = 16;

    localparam int CMD_W     = 2;
    localparam int ID_W      = 32;
    localparam int PRICE_W   = 24;
    localparam int QTY_W     = 24;
    localparam int LIM_W     = 5;
    localparam int STAT_W    = 3;
    localparam int TOT_OUT_W = 32;
    localparam int CNT_OUT_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_VOLUME = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_INACTIVE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_ESTEP,
        OP_LSTART,
        OP_LSTEP,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_LVL_WR,
        OP_ENT_WR,
        OP_OUT_LOAD,
        OP_LIST_RD,
        OP_LIST_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ESCAN,
        S_EDEC,
        S_LSCAN,
        S_LDEC,
        S_SH_RD,
        S_SH_WR,
        S_LVL_WR,
        S_ENT_WR,
        S_RESP,
        S_LIST_RD,
        S_LIST_OUT
    } fsm_state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             act;
        logic             escan_done;
        logic             e_found;
        logic             e_free;
        logic             lscan_done;
        logic             l_found;
        logic             lvl_full;
        logic             del_empty;
        logic             sh_more;
        logic             list_empty;
        logic             list_last;
        logic             out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [PRICE_W-1:0]   level_price;
        logic [TOT_OUT_W-1:0] quantity_total;
        logic [CNT_OUT_W-1:0] level_orders;
        logic [PRICE_W-1:0]   best_bid;
        logic [PRICE_W-1:0]   best_ask;
        logic [CNT_OUT_W-1:0] order_count;
        logic                 last;
    } rsp_t;

endpackage

### hdl/lobt_req_if.sv
// Command channel interface: valid/ready handshake with the command payload.
// Depends on lobt_pkg for field widths.
interface lobt_req_if import lobt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    order_id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic               active;
    logic [LIM_W-1:0]   level_limit;

    modport source (output valid, cmd, order_id, side, price, quantity, active, level_limit,
                    input ready);
    modport sink (input valid, cmd, order_id, side, price, quantity, active, level_limit,
                  output ready);
endinterface

### hdl/lobt_rsp_if.sv
// Result channel interface: valid/ready handshake with the result payload.
// Depends on lobt_pkg for field widths.
interface lobt_rsp_if import lobt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [PRICE_W-1:0]   level_price;
    logic [TOT_OUT_W-1:0] quantity_total;
    logic [CNT_OUT_W-1:0] level_orders;
    logic [PRICE_W-1:0]   best_bid;
    logic [PRICE_W-1:0]   best_ask;
    logic [CNT_OUT_W-1:0] order_count;
    logic                 last;

    modport source (output valid, status, level_price, quantity_total, level_orders,
                    best_bid, best_ask, order_count, last, input ready);
    modport sink (input valid, status, level_price, quantity_total, level_orders,
                  best_bid, best_ask, order_count, last, output ready);
endinterface

### hdl/lobt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lobt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/lobt_ctrl.sv
// Controller state machine: sequences scans, level shifts, table writes and results.
// Depends on lobt_pkg; drives lobt_dp through dp_cmd_t, reads dp_stat_t.
module lobt_ctrl import lobt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             req_ready,
    input  dp_stat_t         stat,
    output dp_cmd_t          dcmd
);
    fsm_state_t state_reg, state_next;
    status_t    status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        dcmd.op     = OP_NOP;
        dcmd.status = status_reg;
        req_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    dcmd.op     = OP_LATCH;
                    status_next = ST_OK;
                    // branch on the incoming item, the latched copy is not there yet
                    case (req_cmd)
                        CMD_ADD, CMD_CANCEL: state_next = S_ESCAN;
                        CMD_VOLUME:          state_next = S_LSCAN;
                        default:             state_next = S_LIST_RD;
                    endcase
                end
            end
            S_ESCAN:
            begin
                if (stat.escan_done)
                begin
                    state_next = S_EDEC;
                end
                else
                begin
                    dcmd.op = OP_ESTEP;
                end
            end
            S_EDEC:
            begin
                if (stat.cmd == CMD_ADD)
                begin
                    if (stat.e_found)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_RESP;
                    end
                    else if (!stat.act)
                    begin
                        status_next = ST_INACTIVE;
                        state_next  = S_RESP;
                    end
                    else if (!stat.e_free)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        dcmd.op    = OP_LSTART;
                        state_next = S_LSCAN;
                    end
                end
                else if (!stat.e_found)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    dcmd.op    = OP_LSTART;
                    state_next = S_LSCAN;
                end
            end
            S_LSCAN:
            begin
                if (stat.lscan_done)
                begin
                    state_next = S_LDEC;
                end
                else
                begin
                    dcmd.op = OP_LSTEP;
                end
            end
            S_LDEC:
            begin
                case (stat.cmd)
                    CMD_VOLUME:
                    begin
                        state_next = S_RESP;
                    end
                    CMD_ADD:
                    begin
                        if (stat.l_found)
                        begin
                            state_next = S_LVL_WR;
                        end
                        else if (stat.lvl_full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            dcmd.op    = OP_SH_INIT;
                            state_next = S_SH_RD;
                        end
                    end
                    default:
                    begin
                        if (!stat.l_found)
                        begin
                            state_next = S_ENT_WR;
                        end
                        else if (stat.del_empty)
                        begin
                            dcmd.op    = OP_SH_INIT;
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            state_next = S_LVL_WR;
                        end
                    end
                endcase
            end
            S_SH_RD:
            begin
                if (stat.sh_more)
                begin
                    dcmd.op    = OP_SH_RD;
                    state_next = S_SH_WR;
                end
                else if (stat.cmd == CMD_ADD)
                begin
                    state_next = S_LVL_WR;
                end
                else
                begin
                    state_next = S_ENT_WR;
                end
            end
            S_SH_WR:
            begin
                dcmd.op    = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_LVL_WR:
            begin
                dcmd.op    = OP_LVL_WR;
                state_next = S_ENT_WR;
            end
            S_ENT_WR:
            begin
                dcmd.op    = OP_ENT_WR;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    dcmd.op    = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                if (stat.list_empty)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    dcmd.op    = OP_LIST_RD;
                    state_next = S_LIST_OUT;
                end
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    dcmd.op    = OP_LIST_LOAD;
                    state_next = stat.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### hdl/lobt_dp.sv
// Datapath: order table, sorted level tables, scan and shift counters, result register.
// Depends on lobt_pkg and lobt_ram; commanded by lobt_ctrl.
module lobt_dp import lobt_pkg::*; #(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int MAX_LIST   = MAX_LIST_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dcmd,
    output dp_stat_t           stat,
    input  logic [CMD_W-1:0]   in_cmd,
    input  logic [ID_W-1:0]    in_id,
    input  logic               in_side,
    input  logic [PRICE_W-1:0] in_price,
    input  logic [QTY_W-1:0]   in_qty,
    input  logic               in_act,
    input  logic [LIM_W-1:0]   in_lim,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp_data
);
    localparam int ORD_AW  = $clog2(MAX_ORDERS);
    localparam int ORD_CW  = $clog2(MAX_ORDERS + 1);
    localparam int LVL_AW  = $clog2(MAX_LEVELS);
    localparam int LVL_CW  = $clog2(MAX_LEVELS + 1);
    localparam int LIST_CW = $clog2(MAX_LIST + 1);
    localparam int TOT_W   = QTY_W + ORD_CW;
    localparam int TOT_X   = (TOT_W > TOT_OUT_W) ? TOT_W : TOT_OUT_W + 1;
    localparam int ENT_W   = ID_W + 1 + PRICE_W + QTY_W;
    localparam int LVL_W   = PRICE_W + TOT_W + ORD_CW;
    localparam int LVL_D   = 2 ** (LVL_AW + 1);

    // latched command
    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic               act_reg;

    // persistent state
    logic [MAX_ORDERS-1:0] valid_reg;
    logic [LVL_CW-1:0]     used_reg [2];
    logic [PRICE_W-1:0]    best_reg [2];
    logic [ORD_CW-1:0]     resting_reg;

    // order table scan
    logic [ORD_CW-1:0]  e_cnt_reg;
    logic               e_pv_reg;
    logic [ORD_AW-1:0]  e_pidx_reg;
    logic               e_found_reg;
    logic [ORD_AW-1:0]  e_idx_reg;
    logic               e_free_reg;
    logic [ORD_AW-1:0]  f_idx_reg;
    logic               e_side_reg;
    logic [PRICE_W-1:0] e_price_reg;
    logic [QTY_W-1:0]   e_rem_reg;

    // level scan
    logic               k_side_reg;
    logic [PRICE_W-1:0] k_price_reg;
    logic [LVL_CW-1:0]  l_cnt_reg;
    logic               l_pv_reg;
    logic [LVL_AW-1:0]  l_pidx_reg;
    logic               l_found_reg;
    logic [LVL_AW-1:0]  l_idx_reg;
    logic [TOT_W-1:0]   l_tot_reg;
    logic [ORD_CW-1:0]  l_ord_reg;
    logic [LVL_CW-1:0]  pos_reg;
    logic               pos_found_reg;
    logic [LVL_CW-1:0]  sh_j_reg;
    logic               del_reg;
    logic [LIST_CW-1:0] list_n_reg;
    logic [LIST_CW-1:0] list_i_reg;
    logic               o_valid_reg;
    rsp_t               o_data_reg;

    // memories
    logic                ent_we;
    logic [ORD_AW-1:0]   ent_waddr;
    logic [ENT_W-1:0]    ent_wdata;
    logic                ent_re;
    logic [ENT_W-1:0]    ent_rdata;
    logic [ID_W-1:0]     ent_id;
    logic                ent_side;
    logic [PRICE_W-1:0]  ent_price;
    logic [QTY_W-1:0]    ent_rem;
    logic                lvl_we;
    logic [LVL_AW:0]     lvl_waddr;
    logic [LVL_W-1:0]    lvl_wdata;
    logic                lvl_re;
    logic [LVL_AW:0]     lvl_raddr;
    logic [LVL_W-1:0]    lvl_rdata;
    logic [PRICE_W-1:0]  lr_price;
    logic [TOT_W-1:0]    lr_tot;
    logic [ORD_CW-1:0]   lr_ord;

    logic               is_add;
    logic               ls_side;
    logic [LVL_CW-1:0]  ls_used;
    logic               lvl_worse;
    logic [LVL_AW-1:0]  sh_src;
    logic [LVL_AW-1:0]  upd_idx;
    logic [TOT_W-1:0]   rem_x;
    logic [TOT_W-1:0]   cancel_tot;
    logic [LIST_CW-1:0] list_n_calc;
    int                 n_int;
    logic [TOT_OUT_W-1:0] vol_tot;
    logic [TOT_OUT_W-1:0] list_tot;
    logic [TOT_X-1:0]   vol_x;
    logic [TOT_X-1:0]   list_x;

    lobt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ORDERS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (e_cnt_reg[ORD_AW-1:0]),
        .rdata (ent_rdata)
    );

    lobt_ram #(.WIDTH(LVL_W), .DEPTH(LVL_D)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .re    (lvl_re),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    assign {ent_id, ent_side, ent_price, ent_rem} = ent_rdata;
    assign {lr_price, lr_tot, lr_ord}              = lvl_rdata;

    assign is_add  = (cmd_reg == CMD_ADD);
    assign ls_side = (cmd_reg == CMD_CANCEL) ? e_side_reg : side_reg;
    assign ls_used = used_reg[ls_side];
    // bids sort by falling price, asks by rising price
    assign lvl_worse = k_side_reg ? (lr_price > k_price_reg) : (lr_price < k_price_reg);
    assign sh_src  = is_add ? LVL_AW'(sh_j_reg - 1'b1) : LVL_AW'(sh_j_reg + 1'b1);
    assign upd_idx = (is_add && !l_found_reg) ? LVL_AW'(pos_reg) : l_idx_reg;
    assign rem_x   = TOT_W'(e_rem_reg);
    assign cancel_tot = (l_tot_reg >= rem_x) ? (l_tot_reg - rem_x) : '0;

    always_comb
    begin
        n_int = int'(in_lim);
        if (n_int > MAX_LIST)
        begin
            n_int = MAX_LIST;
        end
        if (n_int > int'(used_reg[in_side]))
        begin
            n_int = int'(used_reg[in_side]);
        end
        list_n_calc = LIST_CW'(n_int);
    end

    // totals are exact internally; saturate only on the way out
    always_comb
    begin
        vol_x    = TOT_X'(l_tot_reg);
        list_x   = TOT_X'(lr_tot);
        vol_tot  = (|vol_x[TOT_X-1:TOT_OUT_W]) ? '1 : vol_x[TOT_OUT_W-1:0];
        list_tot = (|list_x[TOT_X-1:TOT_OUT_W]) ? '1 : list_x[TOT_OUT_W-1:0];
    end

    // memory port control
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = f_idx_reg;
        ent_wdata = {id_reg, side_reg, price_reg, qty_reg};
        ent_re    = (dcmd.op == OP_ESTEP) && (e_cnt_reg != ORD_CW'(MAX_ORDERS));
        lvl_we    = 1'b0;
        lvl_waddr = {k_side_reg, upd_idx};
        lvl_wdata = {k_price_reg, l_tot_reg, l_ord_reg};
        lvl_re    = 1'b0;
        lvl_raddr = {k_side_reg, LVL_AW'(l_cnt_reg)};
        case (dcmd.op)
            OP_LSTEP:
            begin
                lvl_re = (l_cnt_reg != used_reg[k_side_reg]);
            end
            OP_SH_RD:
            begin
                lvl_re    = 1'b1;
                lvl_raddr = {k_side_reg, sh_src};
            end
            OP_SH_WR:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = {k_side_reg, LVL_AW'(sh_j_reg)};
                lvl_wdata = lvl_rdata;
            end
            OP_LVL_WR:
            begin
                lvl_we = 1'b1;
                if (!is_add)
                begin
                    lvl_wdata = {k_price_reg, cancel_tot, l_ord_reg - 1'b1};
                end
                else if (l_found_reg)
                begin
                    lvl_wdata = {k_price_reg, l_tot_reg + TOT_W'(qty_reg), l_ord_reg + 1'b1};
                end
                else
                begin
                    lvl_wdata = {k_price_reg, TOT_W'(qty_reg), ORD_CW'(1)};
                end
            end
            OP_ENT_WR:
            begin
                ent_we = is_add;
            end
            OP_LIST_RD:
            begin
                lvl_re    = 1'b1;
                lvl_raddr = {side_reg, LVL_AW'(list_i_reg)};
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            used_reg[0]   <= '0;
            used_reg[1]   <= '0;
            resting_reg   <= '0;
            e_cnt_reg     <= '0;
            e_pv_reg      <= 1'b0;
            e_found_reg   <= 1'b0;
            e_free_reg    <= 1'b0;
            l_cnt_reg     <= '0;
            l_pv_reg      <= 1'b0;
            l_found_reg   <= 1'b0;
            pos_found_reg <= 1'b0;
            sh_j_reg      <= '0;
            del_reg       <= 1'b0;
            list_n_reg    <= '0;
            list_i_reg    <= '0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            if (dcmd.op == OP_OUT_LOAD || dcmd.op == OP_LIST_LOAD)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                o_valid_reg <= 1'b0;
            end
            case (dcmd.op)
                OP_LATCH:
                begin
                    e_cnt_reg     <= '0;
                    e_pv_reg      <= 1'b0;
                    e_found_reg   <= 1'b0;
                    e_free_reg    <= 1'b0;
                    l_cnt_reg     <= '0;
                    l_pv_reg      <= 1'b0;
                    l_found_reg   <= 1'b0;
                    pos_found_reg <= 1'b0;
                    del_reg       <= 1'b0;
                    list_n_reg    <= list_n_calc;
                    list_i_reg    <= '0;
                end
                OP_ESTEP:
                begin
                    e_pv_reg <= (e_cnt_reg != ORD_CW'(MAX_ORDERS));
                    if (e_cnt_reg != ORD_CW'(MAX_ORDERS))
                    begin
                        e_cnt_reg <= e_cnt_reg + 1'b1;
                        if (!e_free_reg && !valid_reg[e_cnt_reg[ORD_AW-1:0]])
                        begin
                            e_free_reg <= 1'b1;
                        end
                    end
                    if (e_pv_reg && valid_reg[e_pidx_reg] && ent_id == id_reg)
                    begin
                        e_found_reg <= 1'b1;
                    end
                end
                OP_LSTART:
                begin
                    l_cnt_reg     <= '0;
                    l_pv_reg      <= 1'b0;
                    l_found_reg   <= 1'b0;
                    pos_found_reg <= 1'b0;
                end
                OP_LSTEP:
                begin
                    l_pv_reg <= (l_cnt_reg != used_reg[k_side_reg]);
                    if (l_cnt_reg != used_reg[k_side_reg])
                    begin
                        l_cnt_reg <= l_cnt_reg + 1'b1;
                    end
                    if (l_pv_reg && lr_price == k_price_reg)
                    begin
                        l_found_reg <= 1'b1;
                    end
                    if (l_pv_reg && !pos_found_reg && lvl_worse)
                    begin
                        pos_found_reg <= 1'b1;
                    end
                end
                OP_SH_INIT:
                begin
                    sh_j_reg <= is_add ? used_reg[k_side_reg] : LVL_CW'(l_idx_reg);
                    del_reg  <= !is_add;
                end
                OP_SH_WR:
                begin
                    sh_j_reg <= is_add ? sh_j_reg - 1'b1 : sh_j_reg + 1'b1;
                end
                OP_LVL_WR:
                begin
                    if (is_add && !l_found_reg)
                    begin
                        used_reg[k_side_reg] <= used_reg[k_side_reg] + 1'b1;
                    end
                end
                OP_ENT_WR:
                begin
                    if (is_add)
                    begin
                        valid_reg[f_idx_reg] <= 1'b1;
                        resting_reg          <= resting_reg + 1'b1;
                    end
                    else
                    begin
                        valid_reg[e_idx_reg] <= 1'b0;
                        if (resting_reg != '0)
                        begin
                            resting_reg <= resting_reg - 1'b1;
                        end
                        if (del_reg)
                        begin
                            used_reg[k_side_reg] <= used_reg[k_side_reg] - 1'b1;
                        end
                    end
                end
                OP_LIST_LOAD:
                begin
                    list_i_reg <= list_i_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (dcmd.op)
            OP_LATCH:
            begin
                cmd_reg     <= in_cmd;
                id_reg      <= in_id;
                side_reg    <= in_side;
                price_reg   <= in_price;
                qty_reg     <= in_qty;
                act_reg     <= in_act;
                k_side_reg  <= in_side;
                k_price_reg <= in_price;
                pos_reg     <= used_reg[in_side];
            end
            OP_ESTEP:
            begin
                e_pidx_reg <= e_cnt_reg[ORD_AW-1:0];
                if (e_cnt_reg != ORD_CW'(MAX_ORDERS) && !e_free_reg
                    && !valid_reg[e_cnt_reg[ORD_AW-1:0]])
                begin
                    f_idx_reg <= e_cnt_reg[ORD_AW-1:0];
                end
                if (e_pv_reg && valid_reg[e_pidx_reg] && ent_id == id_reg)
                begin
                    e_idx_reg   <= e_pidx_reg;
                    e_side_reg  <= ent_side;
                    e_price_reg <= ent_price;
                    e_rem_reg   <= ent_rem;
                end
            end
            OP_LSTART:
            begin
                k_side_reg  <= ls_side;
                k_price_reg <= (cmd_reg == CMD_CANCEL) ? e_price_reg : price_reg;
                pos_reg     <= ls_used;
            end
            OP_LSTEP:
            begin
                l_pidx_reg <= LVL_AW'(l_cnt_reg);
                if (l_pv_reg && lr_price == k_price_reg)
                begin
                    l_idx_reg <= l_pidx_reg;
                    l_tot_reg <= lr_tot;
                    l_ord_reg <= lr_ord;
                end
                if (l_pv_reg && !pos_found_reg && lvl_worse)
                begin
                    pos_reg <= LVL_CW'(l_pidx_reg);
                end
            end
            OP_OUT_LOAD:
            begin
                o_data_reg.status         <= dcmd.status;
                o_data_reg.level_price    <= (cmd_reg == CMD_VOLUME) ? price_reg : '0;
                o_data_reg.quantity_total <= (cmd_reg == CMD_VOLUME && l_found_reg)
                                             ? vol_tot : '0;
                o_data_reg.level_orders   <= (cmd_reg == CMD_VOLUME && l_found_reg)
                                             ? CNT_OUT_W'(l_ord_reg) : '0;
                o_data_reg.best_bid       <= (used_reg[0] != '0) ? best_reg[0] : '0;
                o_data_reg.best_ask       <= (used_reg[1] != '0) ? best_reg[1] : '0;
                o_data_reg.order_count    <= CNT_OUT_W'(resting_reg);
                o_data_reg.last           <= 1'b1;
            end
            OP_LIST_LOAD:
            begin
                o_data_reg.status         <= ST_OK;
                o_data_reg.level_price    <= lr_price;
                o_data_reg.quantity_total <= list_tot;
                o_data_reg.level_orders   <= CNT_OUT_W'(lr_ord);
                o_data_reg.best_bid       <= (used_reg[0] != '0) ? best_reg[0] : '0;
                o_data_reg.best_ask       <= (used_reg[1] != '0) ? best_reg[1] : '0;
                o_data_reg.order_count    <= CNT_OUT_W'(resting_reg);
                o_data_reg.last           <= (LIST_CW'(list_i_reg + 1'b1) == list_n_reg);
            end
            default:
            begin
            end
        endcase
        // best price tracks every write to the head level of a side
        if (lvl_we && lvl_waddr[LVL_AW-1:0] == '0)
        begin
            best_reg[lvl_waddr[LVL_AW]] <= lvl_wdata[LVL_W-1 -: PRICE_W];
        end
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.act        = act_reg;
        stat.escan_done = (e_cnt_reg == ORD_CW'(MAX_ORDERS)) && !e_pv_reg;
        stat.e_found    = e_found_reg;
        stat.e_free     = e_free_reg;
        stat.lscan_done = (l_cnt_reg == used_reg[k_side_reg]) && !l_pv_reg;
        stat.l_found    = l_found_reg;
        stat.lvl_full   = (used_reg[k_side_reg] == LVL_CW'(MAX_LEVELS));
        stat.del_empty  = (l_ord_reg <= ORD_CW'(1));
        stat.sh_more    = is_add ? (sh_j_reg > pos_reg)
                                 : ((sh_j_reg + 1'b1) < used_reg[k_side_reg]);
        stat.list_empty = (list_n_reg == '0);
        stat.list_last  = (LIST_CW'(list_i_reg + 1'b1) == list_n_reg);
        stat.out_free   = !o_valid_reg || rsp_ready;
    end

    assign rsp_valid = o_valid_reg;
    assign rsp_data  = o_data_reg;
endmodule

### hdl/limit_order_book_table_core.sv
// Limit order book core. Add/cancel run the id scan (one entry per cycle), the level
// scan (one level per cycle) and the level shift, which reads then writes each shifted
// level; rejects from the id scan and unknown ids stop after the id scan. Volume runs
// the level scan; list reads each listed level and loads it into the output register.
// One command in flight; the next is taken while the last result waits in the output register.
// Reset (async, active low) empties the order table (valid flops) and both level lists.
module limit_order_book_table_core import lobt_pkg::*; #(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int MAX_LIST   = MAX_LIST_DEF
) (
    input logic  clk,
    input logic  rst_n,
    lobt_req_if.sink   req,
    lobt_rsp_if.source rsp
);
    dp_cmd_t  dcmd;
    dp_stat_t stat;
    rsp_t     rsp_data;
    logic     ready;

    lobt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (ready),
        .stat      (stat),
        .dcmd      (dcmd)
    );

    lobt_dp #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_LIST   (MAX_LIST)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dcmd      (dcmd),
        .stat      (stat),
        .in_cmd    (req.cmd),
        .in_id     (req.order_id),
        .in_side   (req.side),
        .in_price  (req.price),
        .in_qty    (req.quantity),
        .in_act    (req.active),
        .in_lim    (req.level_limit),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    assign req.ready          = ready;
    assign rsp.status         = rsp_data.status;
    assign rsp.level_price    = rsp_data.level_price;
    assign rsp.quantity_total = rsp_data.quantity_total;
    assign rsp.level_orders   = rsp_data.level_orders;
    assign rsp.best_bid       = rsp_data.best_bid;
    assign rsp.best_ask       = rsp_data.best_ask;
    assign rsp.order_count    = rsp_data.order_count;
    assign rsp.last           = rsp_data.last;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_OUT_LOAD || dcmd.op == OP_LIST_LOAD) |-> stat.out_free)
        else $error("result loaded over an untaken item");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second command taken while one is in work");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.last)
        else $error("error result not marked last");
endmodule

### verif/limit_order_book_table_core_tb.sv
// Testbench for limit_order_book_table_core: random and directed order book commands,
// checked against an in-bench book model. Depends on lobt_pkg, lobt_req_if, lobt_rsp_if.
`timescale 1ns / 1ps

module limit_order_book_table_core_tb;
    import lobt_pkg::*;

    localparam int NORD = MAX_ORDERS_DEF;
    localparam int NLVL = MAX_LEVELS_DEF;
    localparam int NLIST = MAX_LIST_DEF;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    order_id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
        logic               active;
        logic [LIM_W-1:0]   level_limit;
    } book_cmd_t;

    logic clk;
    logic rst_n;

    lobt_req_if req ();
    lobt_rsp_if rsp ();

    limit_order_book_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // book model state
    bit                 ord_valid [NORD];
    logic [ID_W-1:0]    ord_id [NORD];
    bit                 ord_side [NORD];
    logic [PRICE_W-1:0] ord_price [NORD];
    logic [QTY_W-1:0]   ord_qty [NORD];
    logic [PRICE_W-1:0] lvl_price [2][NLVL];
    longint unsigned    lvl_total [2][NLVL];
    int                 lvl_orders [2][NLVL];
    int                 lvl_used [2];
    int                 resting;

    book_cmd_t cmd_q[$];
    rsp_t      expected_q[$];
    int        errors;
    bit        stim_done;
    int        idle_cycles;
    logic [ID_W-1:0] used_ids[$];

    function automatic void queue_cmd(book_cmd_t c);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic void expect_rsp(rsp_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic string rsp_str(rsp_t r);
        return $sformatf("st=%0d lp=%0d qt=%0d lo=%0d bb=%0d ba=%0d oc=%0d l=%0d",
                         r.status, r.level_price, r.quantity_total, r.level_orders,
                         r.best_bid, r.best_ask, r.order_count, r.last);
    endfunction

    function automatic int find_lvl(bit s, logic [PRICE_W-1:0] p);
        for (int i = 0; i < lvl_used[s]; i++)
            if (lvl_price[s][i] == p)
                return i;
        return -1;
    endfunction

    function automatic int find_ord(logic [ID_W-1:0] id);
        for (int i = 0; i < NORD; i++)
            if (ord_valid[i] && ord_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic rsp_t make_rsp(status_t st, logic [PRICE_W-1:0] lp,
                                      longint unsigned qt, int lo, bit lst);
        rsp_t r;
        r.status = st;
        r.level_price = lp;
        r.quantity_total = (qt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : qt[31:0];
        r.level_orders = CNT_OUT_W'(lo);
        r.best_bid = lvl_used[0] > 0 ? lvl_price[0][0] : '0;
        r.best_ask = lvl_used[1] > 0 ? lvl_price[1][0] : '0;
        r.order_count = CNT_OUT_W'(resting);
        r.last = lst;
        return r;
    endfunction

    function automatic status_t book_add(book_cmd_t c);
        int slot;
        int lv;
        int pos;
        bit s;
        slot = -1;
        s = c.side;
        if (find_ord(c.order_id) >= 0)
            return ST_DUP;
        if (!c.active)
            return ST_INACTIVE;
        for (int i = 0; i < NORD; i++)
            if (!ord_valid[i])
            begin
                slot = i;
                break;
            end
        if (slot < 0)
            return ST_FULL;
        lv = find_lvl(s, c.price);
        if (lv < 0)
        begin
            if (lvl_used[s] >= NLVL)
                return ST_FULL;
            pos = lvl_used[s];
            for (int i = 0; i < lvl_used[s]; i++)
                if (s == 1'b0 ? lvl_price[s][i] < c.price : lvl_price[s][i] > c.price)
                begin
                    pos = i;
                    break;
                end
            for (int j = lvl_used[s]; j > pos; j--)
            begin
                lvl_price[s][j] = lvl_price[s][j-1];
                lvl_total[s][j] = lvl_total[s][j-1];
                lvl_orders[s][j] = lvl_orders[s][j-1];
            end
            lvl_price[s][pos] = c.price;
            lvl_total[s][pos] = 0;
            lvl_orders[s][pos] = 0;
            lvl_used[s]++;
            lv = pos;
        end
        lvl_total[s][lv] += c.quantity;
        lvl_orders[s][lv]++;
        ord_valid[slot] = 1'b1;
        ord_id[slot] = c.order_id;
        ord_side[slot] = s;
        ord_price[slot] = c.price;
        ord_qty[slot] = c.quantity;
        resting++;
        return ST_OK;
    endfunction

    function automatic status_t book_cancel(logic [ID_W-1:0] id);
        int e;
        int lv;
        bit s;
        e = find_ord(id);
        if (e < 0)
            return ST_NOT_FOUND;
        s = ord_side[e];
        lv = find_lvl(s, ord_price[e]);
        if (lv >= 0)
        begin
            lvl_total[s][lv] = lvl_total[s][lv] >= ord_qty[e] ? lvl_total[s][lv] - ord_qty[e] : 0;
            if (lvl_orders[s][lv] > 0)
                lvl_orders[s][lv]--;
            if (lvl_orders[s][lv] == 0)
            begin
                for (int j = lv; j + 1 < lvl_used[s]; j++)
                begin
                    lvl_price[s][j] = lvl_price[s][j+1];
                    lvl_total[s][j] = lvl_total[s][j+1];
                    lvl_orders[s][j] = lvl_orders[s][j+1];
                end
                lvl_used[s]--;
            end
        end
        ord_valid[e] = 1'b0;
        if (resting > 0)
            resting--;
        return ST_OK;
    endfunction

    task automatic predict_book(book_cmd_t c);
        int lv;
        int n;
        bit s;
        s = c.side;
        case (c.cmd)
            CMD_ADD: expect_rsp(make_rsp(book_add(c), '0, 0, 0, 1'b1));
            CMD_CANCEL: expect_rsp(make_rsp(book_cancel(c.order_id), '0, 0, 0, 1'b1));
            CMD_VOLUME:
            begin
                lv = find_lvl(s, c.price);
                if (lv < 0)
                    expect_rsp(make_rsp(ST_OK, c.price, 0, 0, 1'b1));
                else
                    expect_rsp(make_rsp(ST_OK, c.price, lvl_total[s][lv],
                                        lvl_orders[s][lv], 1'b1));
            end
            default:
            begin
                n = c.level_limit;
                if (n > NLIST) n = NLIST;
                if (n > lvl_used[s]) n = lvl_used[s];
                if (n == 0)
                    expect_rsp(make_rsp(ST_OK, '0, 0, 0, 1'b1));
                for (int i = 0; i < n; i++)
                    expect_rsp(make_rsp(ST_OK, lvl_price[s][i], lvl_total[s][i],
                                        lvl_orders[s][i], i + 1 == n));
            end
        endcase
    endtask

    function automatic book_cmd_t mk(cmd_t op, logic [ID_W-1:0] id, bit s,
                                     logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q,
                                     bit act, logic [LIM_W-1:0] lim);
        book_cmd_t c;
        c.cmd = op;
        c.order_id = id;
        c.side = s;
        c.price = p;
        c.quantity = q;
        c.active = act;
        c.level_limit = lim;
        return c;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 2) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom();
    endfunction

    // price from a narrow band so levels repeat, now and then a wide one
    function automatic logic [PRICE_W-1:0] pick_price();
        if ($urandom_range(0, 9) == 0)
            return PRICE_W'($urandom_range(0, 24'hFFFFFF));
        return PRICE_W'(10000 + $urandom_range(0, 40));
    endfunction

    function automatic book_cmd_t rand_cmd();
        book_cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c = mk(CMD_ADD, pick_id(), 1'($urandom_range(0, 1)), pick_price(),
               $urandom_range(0, 1) ? QTY_W'($urandom_range(0, 24'hFFFFFF))
                                    : QTY_W'($urandom_range(1, 500)),
               $urandom_range(0, 15) != 0, LIM_W'($urandom_range(0, 31)));
        if (r < 50)
        begin
            c.cmd = CMD_ADD;
            if ($urandom_range(0, 3) != 0)
                c.order_id = $urandom();
            used_ids.insert(used_ids.size(), c.order_id);
        end
        else if (r < 75)
            c.cmd = CMD_CANCEL;
        else if (r < 87)
            c.cmd = CMD_VOLUME;
        else
            c.cmd = CMD_LIST;
        return c;
    endfunction

    initial
    begin
        book_cmd_t c;
        rst_n = 1'b0;
        stim_done = 1'b0;
        errors = 0;
        lvl_used[0] = 0;
        lvl_used[1] = 0;
        resting = 0;
        for (int i = 0; i < NORD; i++)
            ord_valid[i] = 1'b0;

        // directed: empty book, extremes, every status
        queue_cmd(mk(CMD_LIST, 0, 0, 0, 0, 1, 16));
        queue_cmd(mk(CMD_VOLUME, 0, 1, 24'hFFFFFF, 0, 1, 0));
        queue_cmd(mk(CMD_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 1, 0));
        queue_cmd(mk(CMD_ADD, 32'hFFFF_FFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 0));
        queue_cmd(mk(CMD_ADD, 0, 1, 0, 0, 1, 0));
        queue_cmd(mk(CMD_ADD, 32'hFFFF_FFFF, 1, 5, 5, 1, 0));
        queue_cmd(mk(CMD_ADD, 7, 1, 5, 5, 0, 0));
        queue_cmd(mk(CMD_ADD, 8, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 0));
        queue_cmd(mk(CMD_ADD, 9, 0, 100, 3, 1, 0));
        queue_cmd(mk(CMD_ADD, 10, 1, 24'hAAAAAA, 24'h555555, 1, 0));
        queue_cmd(mk(CMD_VOLUME, 0, 0, 24'hFFFFFF, 0, 0, 0));
        queue_cmd(mk(CMD_LIST, 0, 0, 0, 0, 0, 31));
        queue_cmd(mk(CMD_LIST, 0, 1, 0, 0, 0, 1));
        queue_cmd(mk(CMD_LIST, 0, 1, 0, 0, 0, 0));
        queue_cmd(mk(CMD_CANCEL, 9, 0, 0, 0, 0, 0));
        queue_cmd(mk(CMD_CANCEL, 9, 0, 0, 0, 0, 0));
        queue_cmd(mk(CMD_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        queue_cmd(mk(CMD_LIST, 0, 0, 0, 0, 0, 16));
        // fill the bid level table and then the order table
        for (int i = 0; i < 3; i++)
            queue_cmd(mk(CMD_ADD, 100 + i, 1, 24'hFFFFFF, 24'hFFFFFF, 1, 0));
        for (int i = 0; i < 70; i++)
            queue_cmd(mk(CMD_ADD, 1000 + i, 0, 500 + i, 1, 1, 0));
        for (int i = 0; i < 190; i++)
            queue_cmd(mk(CMD_ADD, 2000 + i, 1, 24'hFFFFFF, 24'hFFFFFF, 1, 0));
        queue_cmd(mk(CMD_VOLUME, 0, 1, 24'hFFFFFF, 0, 0, 0));
        queue_cmd(mk(CMD_LIST, 0, 0, 0, 0, 0, 20));
        for (int i = 0; i < 70; i++)
            queue_cmd(mk(CMD_CANCEL, 1000 + i, 0, 0, 0, 0, 0));
        for (int i = 0; i < 120; i++)
        begin
            c = rand_cmd();
            queue_cmd(c);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (cmd_q.size() == 0);
        stim_done = 1'b1;
        wait (expected_q.size() == 0);
        repeat (600) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("limit_order_book_table_core_tb: done, clean");
        else
            $display("limit_order_book_table_core_tb: done, errors");
        $finish;
    end

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.cmd <= CMD_ADD;
            req.order_id <= '0;
            req.side <= 1'b0;
            req.price <= '0;
            req.quantity <= '0;
            req.active <= 1'b0;
            req.level_limit <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                predict_book(cmd_q.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                // next item is the head after any pop above
                req.valid <= 1'b1;
                req.cmd <= cmd_q[0].cmd;
                req.order_id <= cmd_q[0].order_id;
                req.side <= cmd_q[0].side;
                req.price <= cmd_q[0].price;
                req.quantity <= cmd_q[0].quantity;
                req.active <= cmd_q[0].active;
                req.level_limit <= cmd_q[0].level_limit;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 80);
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    // monitor with its own stall pattern
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            rsp.ready <= (stall_phase[8:7] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("limit_order_book_table_core_tb: done, errors");
                $finish;
            end
            if (rsp.valid && rsp.ready)
            begin
                rsp_t e;
                rsp_t a;
                a.status = rsp.status;
                a.level_price = rsp.level_price;
                a.quantity_total = rsp.quantity_total;
                a.level_orders = rsp.level_orders;
                a.best_bid = rsp.best_bid;
                a.best_ask = rsp.best_ask;
                a.order_count = rsp.order_count;
                a.last = rsp.last;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: mismatch expected none, actual %s", $time, rsp_str(a));
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (a !== e)
                    begin
                        $display("%0t: mismatch expected %s", $time, rsp_str(e));
                        $display("%0t: mismatch actual   %s", $time, rsp_str(a));
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule
